[src/efsc_pkg.sv]
// Shared types and constants for the edge-function span coverage unit.
// Used by every module under src; depends on nothing.
package efsc_pkg;

   // Field widths of the beats
   localparam int COORD_W  = 12;
   localparam int COEF_W   = 20;
   localparam int CONST_W  = 40;
   localparam int MASK_W   = 16;
   localparam int EDGES    = 3;

   // Internal arithmetic widths
   // pixel-centre coordinate 2*v+1, signed, with one sign bit above its 13 bits
   localparam int CTR_W    = COORD_W + 2;
   localparam int PROD_W   = COEF_W + CTR_W;
   localparam int VAL_W    = 44;
   localparam int OFF_W    = COEF_W + 5;

   // Request codes
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_SPAN = 1'b1;

   typedef struct packed {
      logic                       req_type;
      logic [1:0]                 edge_index;
      logic signed [COEF_W-1:0]   row_coef;
      logic signed [COEF_W-1:0]   col_coef;
      logic signed [CONST_W-1:0]  const_coef;
      logic [COORD_W-1:0]         row_y;
      logic [COORD_W-1:0]         span_x_start;
      logic [COORD_W-1:0]         span_last_x;
   } req_beat_type;

   typedef struct packed {
      logic [MASK_W-1:0]   coverage_mask;
      logic [COORD_W-1:0]  out_row;
      logic [COORD_W-1:0]  out_x_start;
      logic                any_covered;
   } rsp_beat_type;

   typedef logic signed [VAL_W-1:0] value_type;
   typedef logic signed [OFF_W-1:0] offset_type;

   // Stage load enables of the span pipeline
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } adv_type;

endpackage

[src/edge_function_span_coverage_unit.sv]
// Edge-function span coverage unit: three stored edges, LANES pixel lanes.
// Span path: a request beat that is taken passes the product, base/step, lane
// test and merge registers before its result beat is valid. Throughput: one beat
// per cycle while rsp_stall holds nothing back, loads included; a load gives no result beat.
// Reset: edge stores clear to zero (every pixel covered), pipeline empties.
// Depends on efsc_pkg, efsc_edge, efsc_lane and efsc_merge.
module edge_function_span_coverage_unit #(
   parameter int LANES      = 16,
   parameter int COORD_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  efsc_pkg::req_beat_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output efsc_pkg::rsp_beat_type  rsp_data
);

   localparam logic [efsc_pkg::COORD_W-1:0] CMASK =
      efsc_pkg::COORD_W'((64'd1 << COORD_BITS) - 64'd1);

   logic                            req_acc, load_acc, span_acc;
   logic                            out_free, free1, free2, free3;
   logic                            v1_ff, v2_ff, v3_ff, vo_ff;
   efsc_pkg::adv_type               adv;
   logic [efsc_pkg::COORD_W-1:0]    y0, xs0, xl0;
   logic signed [efsc_pkg::CTR_W-1:0] ty0, tx0;
   logic [efsc_pkg::COORD_W-1:0]    y1_ff, xs1_ff, xl1_ff;
   logic [efsc_pkg::COORD_W-1:0]    y2_ff, xs2_ff, y3_ff, xs3_ff;
   logic [LANES-1:0]                en2_ff, en2_in;
   logic [LANES-1:0]                lane_bits;
   efsc_pkg::value_type             base [efsc_pkg::EDGES];
   efsc_pkg::offset_type            lane_off [efsc_pkg::EDGES][LANES];
   efsc_pkg::offset_type            lane_off_t [LANES][efsc_pkg::EDGES];

   // Handshake and stage advance: a stage moves when the next one frees up
   assign out_free = ~vo_ff | ~rsp_stall;
   assign free3    = ~v3_ff | out_free;
   assign free2    = ~v2_ff | free3;
   assign free1    = ~v1_ff | free2;
   assign req_stall = ~free1;
   assign req_acc  = req_valid & ~req_stall;
   assign load_acc = req_acc & (req_data.req_type == efsc_pkg::REQ_LOAD);
   assign span_acc = req_acc & (req_data.req_type == efsc_pkg::REQ_SPAN);

   always_comb begin
      adv.s1 = span_acc;
      adv.s2 = v1_ff & free2;
      adv.s3 = v2_ff & free3;
      adv.s4 = v3_ff & out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (free1) v1_ff <= span_acc;
         if (free2) v2_ff <= v1_ff;
         if (free3) v3_ff <= v2_ff;
         if (out_free) vo_ff <= v3_ff;
      end
   end

   assign rsp_valid = vo_ff;

   // Coordinates: keep the low COORD_BITS, form pixel centres 2*v+1
   assign y0  = req_data.row_y & CMASK;
   assign xs0 = req_data.span_x_start & CMASK;
   assign xl0 = req_data.span_last_x & CMASK;
   assign ty0 = $signed({1'b0, y0, 1'b1});
   assign tx0 = $signed({1'b0, xs0, 1'b1});

   // Span bookkeeping that travels beside the lanes
   always_ff @(posedge clock) begin
      if (adv.s1) begin
         y1_ff  <= y0;
         xs1_ff <= xs0;
         xl1_ff <= xl0;
      end
      if (adv.s2) begin
         y2_ff  <= y1_ff;
         xs2_ff <= xs1_ff;
         en2_ff <= en2_in;
      end
      if (adv.s3) begin
         y3_ff  <= y2_ff;
         xs3_ff <= xs2_ff;
      end
   end

   // Drop lanes past the last column
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         en2_in[i] = ({1'b0, xs1_ff} + (efsc_pkg::COORD_W + 1)'(i))
                     <= {1'b0, xl1_ff};
      end
   end

   for (genvar e = 0; e < efsc_pkg::EDGES; e++) begin : g_edge
      efsc_edge #(
         .LANES (LANES)
      ) u_edge (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .wr_en      (load_acc && (req_data.edge_index == 2'(e))),
         .row_coef   (req_data.row_coef),
         .col_coef   (req_data.col_coef),
         .const_coef (req_data.const_coef),
         .ty         (ty0),
         .tx         (tx0),
         .base       (base[e]),
         .lane_off   (lane_off[e])
      );
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      for (genvar e = 0; e < efsc_pkg::EDGES; e++) begin : g_tr
         assign lane_off_t[i][e] = lane_off[e][i];
      end

      efsc_lane u_lane (
         .clock   (clock),
         .adv     (adv),
         .lane_en (en2_ff[i]),
         .base    (base),
         .off     (lane_off_t[i]),
         .covered (lane_bits[i])
      );
   end

   efsc_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock     (clock),
      .adv       (adv),
      .lane_bits (lane_bits),
      .row       (y3_ff),
      .x_start   (xs3_ff),
      .rsp_beat  (rsp_data)
   );

endmodule

[src/efsc_edge.sv]
// One edge: coefficient store, product stage and base/lane-offset stage.
// Depends on efsc_pkg.
module efsc_edge #(
   parameter int LANES = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  efsc_pkg::adv_type                      adv,
   input  logic                                   wr_en,
   input  logic signed [efsc_pkg::COEF_W-1:0]     row_coef,
   input  logic signed [efsc_pkg::COEF_W-1:0]     col_coef,
   input  logic signed [efsc_pkg::CONST_W-1:0]    const_coef,
   input  logic signed [efsc_pkg::CTR_W-1:0]      ty,
   input  logic signed [efsc_pkg::CTR_W-1:0]      tx,
   output efsc_pkg::value_type                    base,
   output efsc_pkg::offset_type                   lane_off [LANES]
);

   logic signed [efsc_pkg::COEF_W-1:0]   row_ff, col_ff;
   logic signed [efsc_pkg::CONST_W-1:0]  const_ff;
   logic signed [efsc_pkg::PROD_W-1:0]   pa_ff, pa_in, pb_ff, pb_in;
   logic signed [efsc_pkg::COEF_W-1:0]   b1_ff;
   logic signed [efsc_pkg::CONST_W-1:0]  c1_ff;
   efsc_pkg::value_type                  base_ff, base_in;
   efsc_pkg::offset_type                 off_ff [LANES];
   efsc_pkg::offset_type                 off_in [LANES];

   // Coefficient store, cleared to the all-covering zero edge
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         const_ff <= '0;
      end else if (wr_en) begin
         row_ff   <= row_coef;
         col_ff   <= col_coef;
         const_ff <= const_coef;
      end
   end

   // Stage 1: row and first-column products
   assign pa_in = efsc_pkg::PROD_W'(row_ff) * efsc_pkg::PROD_W'(ty);
   assign pb_in = efsc_pkg::PROD_W'(col_ff) * efsc_pkg::PROD_W'(tx);

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         b1_ff <= col_ff;
         c1_ff <= const_ff;
      end
   end

   // Stage 2: edge value at lane 0, and the step 2*b*i of each lane
   assign base_in = efsc_pkg::VAL_W'(pa_ff) + efsc_pkg::VAL_W'(pb_ff)
                    + (efsc_pkg::VAL_W'(c1_ff) <<< 1);

   for (genvar i = 0; i < LANES; i++) begin : g_off
      assign off_in[i] = efsc_pkg::OFF_W'(b1_ff) * efsc_pkg::OFF_W'(2 * i);
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         base_ff <= base_in;
         off_ff  <= off_in;
      end
   end

   assign base     = base_ff;
   assign lane_off = off_ff;

endmodule

[src/efsc_lane.sv]
// One pixel lane: adds the lane step to each edge value and tests the signs.
// Depends on efsc_pkg.
module efsc_lane (
   input  logic                  clock,
   input  efsc_pkg::adv_type     adv,
   input  logic                  lane_en,
   input  efsc_pkg::value_type   base [efsc_pkg::EDGES],
   input  efsc_pkg::offset_type  off [efsc_pkg::EDGES],
   output logic                  covered
);

   efsc_pkg::value_type  val [efsc_pkg::EDGES];
   logic                 covered_ff, covered_in;

   // Inside when the lane is enabled and every edge value is zero or positive
   always_comb begin
      covered_in = lane_en;
      for (int e = 0; e < efsc_pkg::EDGES; e++) begin
         val[e] = base[e] + efsc_pkg::VAL_W'(off[e]);
         if (val[e][efsc_pkg::VAL_W-1]) begin
            covered_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         covered_ff <= covered_in;
      end
   end

   assign covered = covered_ff;

endmodule

[src/efsc_merge.sv]
// Merge stage: gathers the lane bits into the coverage mask and result beat.
// Depends on efsc_pkg.
module efsc_merge #(
   parameter int LANES = 16
) (
   input  logic                          clock,
   input  efsc_pkg::adv_type             adv,
   input  logic [LANES-1:0]              lane_bits,
   input  logic [efsc_pkg::COORD_W-1:0]  row,
   input  logic [efsc_pkg::COORD_W-1:0]  x_start,
   output efsc_pkg::rsp_beat_type        rsp_beat
);

   efsc_pkg::rsp_beat_type rsp_ff, rsp_in;

   // Build the result beat; mask bits above the lane count stay clear
   always_comb begin
      rsp_in.coverage_mask = efsc_pkg::MASK_W'(lane_bits);
      rsp_in.out_row       = row;
      rsp_in.out_x_start   = x_start;
      rsp_in.any_covered   = |lane_bits;
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_beat = rsp_ff;

endmodule
